[src/mbbc_pkg.sv]
// Package for the masked blob box center block.
// Holds the pixel and result types and the fixed field widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbbc_pkg;

  // Fixed field widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CenterW = 12;
  localparam int unsigned FwW     = 13;

  // Defaults
  localparam int unsigned MaxDimDefault = 4096;
  localparam logic [FwW-1:0] FwReset = 13'd640;
  localparam logic [ChanW-1:0] White = 8'd255;

  // One input pixel
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             end_of_frame;
  } pixel_t;

  // One result item
  typedef struct packed {
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    logic               frame_done;
    logic               object_found;
    logic [CenterW-1:0] center_x;
    logic [CenterW-1:0] center_y;
  } result_t;

  // Tracker status seen by the top level
  typedef struct packed {
    logic seen;
    logic at_origin;
  } status_t;

endpackage : mbbc_pkg

`default_nettype wire

[src/mbbc_tracker.sv]
// Position counters and bounding-box tracker for one pixel per cycle while pix_accept is high.
// Depends on mbbc_pkg for the pixel, result and status types.
`timescale 1ns / 1ps
`default_nettype none

module mbbc_tracker import mbbc_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [FwW-1:0] cfg_width,
  input  wire logic           pix_accept,
  input  wire pixel_t         pix_i,
  output result_t             res_o,
  output status_t             stat_o
);

  localparam int unsigned CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned LW = (FwW > CW + 1) ? FwW : CW + 1;
  localparam logic [LW-1:0] MaxDimL  = LW'(MAX_DIM);
  localparam logic [CW-1:0] RowLimit = CW'(MAX_DIM - 1);

  logic [FwW-1:0] fw_r;
  logic [CW-1:0]  col_r, row_r;
  logic [CW-1:0]  minc_r, maxc_r, minr_r, maxr_r;
  logic           seen_r;

  logic [CW-1:0]  col_nxt, row_nxt;
  logic [CW-1:0]  minc_nxt, maxc_nxt, minr_nxt, maxr_nxt;
  logic           seen_nxt;

  logic           obj, first, ext_minc, ext_maxc, ext_minr, ext_maxr, extend;
  logic [CW-1:0]  minc_u, maxc_u, minr_u, maxr_u;
  logic [LW-1:0]  fw_l, eff_w, next_col;
  logic [CW:0]    sum_x, sum_y;
  logic [CW+CenterW:0] ext_x, ext_y;

  // Object test and box extension against the current extremes
  always_comb begin
    obj      = (|pix_i.red) & (|pix_i.green) & (|pix_i.blue);
    first    = obj & ~seen_r;
    ext_minc = obj & seen_r & (col_r < minc_r);
    ext_maxc = obj & seen_r & (col_r > maxc_r);
    ext_minr = obj & seen_r & (row_r < minr_r);
    ext_maxr = obj & seen_r & (row_r > maxr_r);
    extend   = first | ext_minc | ext_maxc | ext_minr | ext_maxr;
    minc_u   = (first | ext_minc) ? col_r : minc_r;
    maxc_u   = (first | ext_maxc) ? col_r : maxc_r;
    minr_u   = (first | ext_minr) ? row_r : minr_r;
    maxr_u   = (first | ext_maxr) ? row_r : maxr_r;
  end

  // Effective width and column wrap
  always_comb begin
    fw_l = LW'(fw_r);
    if (fw_l == '0) begin
      eff_w = LW'(1);
    end else if (fw_l > MaxDimL) begin
      eff_w = MaxDimL;
    end else begin
      eff_w = fw_l;
    end
    next_col = LW'(col_r) + LW'(1);
  end

  // Midpoints of the box after this pixel, masked to the field width
  always_comb begin
    sum_x = {1'b0, minc_u} + {1'b0, maxc_u};
    sum_y = {1'b0, minr_u} + {1'b0, maxr_u};
    ext_x = {{CenterW{1'b0}}, sum_x};
    ext_y = {{CenterW{1'b0}}, sum_y};
  end

  // Result for the accepted pixel
  always_comb begin
    res_o.red          = extend ? White : pix_i.red;
    res_o.green        = extend ? White : pix_i.green;
    res_o.blue         = extend ? White : pix_i.blue;
    res_o.frame_done   = pix_i.end_of_frame;
    res_o.object_found = pix_i.end_of_frame & (seen_r | first);
    res_o.center_x     = res_o.object_found ? ext_x[CenterW:1] : '0;
    res_o.center_y     = res_o.object_found ? ext_y[CenterW:1] : '0;
  end

  // Next state: clear on frame end, else update box and counters
  always_comb begin
    if (pix_i.end_of_frame) begin
      col_nxt  = '0;
      row_nxt  = '0;
      minc_nxt = '0;
      maxc_nxt = '0;
      minr_nxt = '0;
      maxr_nxt = '0;
      seen_nxt = 1'b0;
    end else begin
      minc_nxt = minc_u;
      maxc_nxt = maxc_u;
      minr_nxt = minr_u;
      maxr_nxt = maxr_u;
      seen_nxt = seen_r | first;
      if (next_col >= eff_w) begin
        col_nxt = '0;
        row_nxt = (row_r < RowLimit) ? row_r + CW'(1) : row_r;
      end else begin
        col_nxt = next_col[CW-1:0];
        row_nxt = row_r;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= FwReset;
      col_r  <= '0;
      row_r  <= '0;
      minc_r <= '0;
      maxc_r <= '0;
      minr_r <= '0;
      maxr_r <= '0;
      seen_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fw_r <= cfg_width;
      end
      if (pix_accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        minc_r <= minc_nxt;
        maxc_r <= maxc_nxt;
        minr_r <= minr_nxt;
        maxr_r <= maxr_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  assign stat_o.seen      = seen_r;
  assign stat_o.at_origin = (col_r == '0) && (row_r == '0);

endmodule : mbbc_tracker

`default_nettype wire

[src/mbbc_out_reg.sv]
// Output register stage for result items, with flow control toward the input.
// Depends on mbbc_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module mbbc_out_reg import mbbc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res_i,
  output logic         up_ready,
  output logic         valid,
  input  wire logic    ready,
  output result_t      res_o
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Stage frees up when empty or when its item is taken this cycle
  assign up_ready = ~valid_r | ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_i;
    end
  end

  assign valid = valid_r;
  assign res_o = res_r;

endmodule : mbbc_out_reg

`default_nettype wire

[src/masked_blob_box_center.sv]
// Top level of the masked blob box center block.
// Depends on mbbc_pkg, mbbc_tracker and mbbc_out_reg.
//
// Takes one raster-ordered RGB pixel per clock and returns one result per pixel,
// on the cycle after acceptance. A pixel with all three channels nonzero is an
// object pixel; one that extends the bounding box passes through as white. The
// pixel flagged with tlast ends the frame: its result carries tlast, object_found
// in tuser and the box midpoints, and the tracker clears for the next frame.
// Throughput is one pixel per cycle, set by the compare-and-update of the tracker
// registers; the only stall is backpressure on the output register. frame_width
// is to be written through the cfg port while the block is idle (not enforced by
// the block); zero acts as one and values above MAX_DIM act as MAX_DIM.
`timescale 1ns / 1ps
`default_nettype none

module masked_blob_box_center import mbbc_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  // config
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [FwW-1:0] cfg_data,     // frame_width
  // pixel in
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [23:0]    in_tdata,     // pixel_red, pixel_green, pixel_blue
  input  wire logic           in_tlast,     // end_of_frame
  // result out
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [47:0]         out_tdata,    // out_red, out_green, out_blue,
                                            // center_x, center_y
  output logic                out_tlast,    // frame_done
  output logic                out_tuser     // object_found
);

  pixel_t  pix;
  result_t res_comb, res_q;
  status_t stat;
  logic    in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = in_tvalid & in_tready;

  // Unpack the request
  always_comb begin
    pix.red          = in_tdata[7:0];
    pix.green        = in_tdata[15:8];
    pix.blue         = in_tdata[23:16];
    pix.end_of_frame = in_tlast;
  end

  mbbc_tracker #(
    .MAX_DIM(MAX_DIM)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_width (cfg_data),
    .pix_accept(in_accept),
    .pix_i     (pix),
    .res_o     (res_comb),
    .stat_o    (stat)
  );

  mbbc_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_accept),
    .res_i   (res_comb),
    .up_ready(in_tready),
    .valid   (out_tvalid),
    .ready   (out_tready),
    .res_o   (res_q)
  );

  // Pack the result
  assign out_tdata = {res_q.center_y, res_q.center_x, res_q.blue, res_q.green, res_q.red};
  assign out_tlast = res_q.frame_done;
  assign out_tuser = res_q.object_found;

  // An accepted pixel always shows up as a result on the next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_tvalid)
    else $error("accepted pixel did not produce a result");

  // Frame end leaves the tracker cleared
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tlast) |=> (stat.at_origin && !stat.seen))
    else $error("tracker not cleared after frame end");

  // Box report fields are zero away from frame end
  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (!out_tuser && out_tdata[47:24] == 24'd0))
    else $error("box report outside frame end");

  // No object seen means no report at frame end
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast && !out_tuser) |-> (out_tdata[47:24] == 24'd0))
    else $error("center nonzero with no object");

endmodule : masked_blob_box_center

`default_nettype wire
